// File: rtl/rsi_pkg.sv
// shared types and constants for the ray/sphere intersection pipeline
// no dependencies
package rsi_pkg;

    localparam int FRONT_STAGES = 6;
    localparam int SQ_STEPS     = 66;
    localparam int DIV_STEPS    = 32;
    localparam int PIPE_STAGES  = FRONT_STAGES + SQ_STEPS + 1 + DIV_STEPS;

    localparam logic [63:0] QUARTER_Q32 = 64'h0000_0000_4000_0000;

    typedef struct packed {
        logic [63:0]  a;
        logic [63:0]  hmag;
        logic         hneg;
        logic         miss;
        logic [131:0] d;
        logic [67:0]  rem;
        logic [65:0]  root;
    } sq_t;

    typedef struct packed {
        logic        ok;
        logic        sat;
        logic [63:0] a;
        logic [63:0] r;
        logic [31:0] nb;
        logic [31:0] q;
    } dv_t;

endpackage

// File: rtl/rsi_front.sv
// front end: dot products, discriminant terms and discriminant over six stages
// depends on rsi_pkg
module rsi_front (
    input  logic          clk,
    input  logic          en,
    input  logic [191:0]  in_data,
    output rsi_pkg::sq_t  sq_out
);
    import rsi_pkg::*;

    logic [63:0]  dd_reg [3];
    logic [63:0]  oo_reg [3];
    logic [63:0]  od_reg [3];
    logic [2:0]   pn_reg;
    logic [63:0]  a2_reg, s2_reg, hp_reg, hn_reg;
    logic [63:0]  a3_reg, hmag3_reg, cmag3_reg;
    logic         hneg3_reg, cneg3_reg, miss3_reg;
    logic [63:0]  p00_reg, p01_reg, p11_reg, q00_reg, q01_reg, q10_reg, q11_reg;
    logic [63:0]  a4_reg, hmag4_reg;
    logic         hneg4_reg, cneg4_reg, miss4_reg;
    logic [127:0] hh_reg, ac_reg;
    logic [63:0]  a5_reg, hmag5_reg;
    logic         hneg5_reg, cneg5_reg, miss5_reg;
    sq_t          out_reg;

    logic [31:0]  xm [3];
    logic [31:0]  dm [3];
    logic [2:0]   pn;
    logic [128:0] diff;
    logic [128:0] dsum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xm[i] = in_data[32*i+31] ? (32'd0 - in_data[32*i +: 32]) : in_data[32*i +: 32];
            dm[i] = in_data[32*i+127] ? (32'd0 - in_data[32*i+96 +: 32])
                                      : in_data[32*i+96 +: 32];
            pn[i] = (!in_data[32*i+31] && (in_data[32*i +: 32] != 32'd0))
                    ^ in_data[32*i+127];
        end
    end

    assign diff = {1'b0, hh_reg} - {1'b0, ac_reg};
    assign dsum = {1'b0, hh_reg} + {1'b0, ac_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: per-axis products of magnitudes
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= 64'(dm[i]) * 64'(dm[i]);
                oo_reg[i] <= 64'(xm[i]) * 64'(xm[i]);
                od_reg[i] <= 64'(xm[i]) * 64'(dm[i]);
            end
            pn_reg <= pn;

            // stage 2: sums
            a2_reg <= dd_reg[0] + dd_reg[1] + dd_reg[2];
            s2_reg <= oo_reg[0] + oo_reg[1] + oo_reg[2];
            hp_reg <= (pn_reg[0] ? 64'd0 : od_reg[0]) + (pn_reg[1] ? 64'd0 : od_reg[1])
                    + (pn_reg[2] ? 64'd0 : od_reg[2]);
            hn_reg <= (pn_reg[0] ? od_reg[0] : 64'd0) + (pn_reg[1] ? od_reg[1] : 64'd0)
                    + (pn_reg[2] ? od_reg[2] : 64'd0);

            // stage 3: signed magnitudes of h and c
            a3_reg    <= a2_reg;
            miss3_reg <= (a2_reg == 64'd0);
            hneg3_reg <= hn_reg > hp_reg;
            hmag3_reg <= (hn_reg > hp_reg) ? hn_reg - hp_reg : hp_reg - hn_reg;
            cneg3_reg <= s2_reg < QUARTER_Q32;
            cmag3_reg <= (s2_reg < QUARTER_Q32) ? QUARTER_Q32 - s2_reg : s2_reg - QUARTER_Q32;

            // stage 4: 32x32 partial products
            p00_reg   <= 64'(hmag3_reg[31:0])  * 64'(hmag3_reg[31:0]);
            p01_reg   <= 64'(hmag3_reg[31:0])  * 64'(hmag3_reg[63:32]);
            p11_reg   <= 64'(hmag3_reg[63:32]) * 64'(hmag3_reg[63:32]);
            q00_reg   <= 64'(a3_reg[31:0])  * 64'(cmag3_reg[31:0]);
            q01_reg   <= 64'(a3_reg[31:0])  * 64'(cmag3_reg[63:32]);
            q10_reg   <= 64'(a3_reg[63:32]) * 64'(cmag3_reg[31:0]);
            q11_reg   <= 64'(a3_reg[63:32]) * 64'(cmag3_reg[63:32]);
            a4_reg    <= a3_reg;
            hmag4_reg <= hmag3_reg;
            hneg4_reg <= hneg3_reg;
            cneg4_reg <= cneg3_reg;
            miss4_reg <= miss3_reg;

            // stage 5: h*h and a*c
            hh_reg    <= {p11_reg, p00_reg} + {31'd0, p01_reg, 33'd0};
            ac_reg    <= {q11_reg, q00_reg} + {32'd0, q01_reg, 32'd0} + {32'd0, q10_reg, 32'd0};
            a5_reg    <= a4_reg;
            hmag5_reg <= hmag4_reg;
            hneg5_reg <= hneg4_reg;
            cneg5_reg <= cneg4_reg;
            miss5_reg <= miss4_reg;

            // stage 6: discriminant
            out_reg.a    <= a5_reg;
            out_reg.hmag <= hmag5_reg;
            out_reg.hneg <= hneg5_reg;
            out_reg.miss <= miss5_reg || (!cneg5_reg && diff[128]);
            out_reg.d    <= {3'd0, (cneg5_reg ? dsum : diff)};
            out_reg.rem  <= '0;
            out_reg.root <= '0;
        end
    end

    assign sq_out = out_reg;

endmodule

// File: rtl/rsi_sqrt_cell.sv
// one digit step of the integer square root chain
// depends on rsi_pkg
module rsi_sqrt_cell (
    input  logic          clk,
    input  logic          en,
    input  rsi_pkg::sq_t  sq_in,
    output rsi_pkg::sq_t  sq_out
);
    import rsi_pkg::*;

    sq_t        out_reg;
    logic [69:0] rem_sh;
    logic [69:0] trial;
    logic [69:0] rem_sub;
    logic        ge;

    assign rem_sh  = {sq_in.rem, sq_in.d[131:130]};
    assign trial   = {2'b00, sq_in.root, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.a    <= sq_in.a;
            out_reg.hmag <= sq_in.hmag;
            out_reg.hneg <= sq_in.hneg;
            out_reg.miss <= sq_in.miss;
            out_reg.d    <= {sq_in.d[129:0], 2'b00};
            out_reg.rem  <= ge ? rem_sub[67:0] : rem_sh[67:0];
            out_reg.root <= {sq_in.root[64:0], ge};
        end
    end

    assign sq_out = out_reg;

endmodule

// File: rtl/rsi_div_cell.sv
// one quotient bit of the restoring divider chain
// depends on rsi_pkg
module rsi_div_cell (
    input  logic          clk,
    input  logic          en,
    input  rsi_pkg::dv_t  dv_in,
    output rsi_pkg::dv_t  dv_out
);
    import rsi_pkg::*;

    dv_t         out_reg;
    logic [64:0] r_sh;
    logic [64:0] r_sub;
    logic        ge;

    assign r_sh  = {dv_in.r, dv_in.nb[31]};
    assign ge    = r_sh >= {1'b0, dv_in.a};
    assign r_sub = r_sh - {1'b0, dv_in.a};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.ok  <= dv_in.ok;
            out_reg.sat <= dv_in.sat;
            out_reg.a   <= dv_in.a;
            out_reg.r   <= ge ? r_sub[63:0] : r_sh[63:0];
            out_reg.nb  <= {dv_in.nb[30:0], 1'b0};
            out_reg.q   <= {dv_in.q[30:0], ge};
        end
    end

    assign dv_out = out_reg;

endmodule

// File: rtl/ray_sphere_intersect_core.sv
// ray against unit-diameter sphere: top level with sqrt and divider cell chains
// depends on rsi_pkg, rsi_front, rsi_sqrt_cell, rsi_div_cell
// depth: 106 register stages from the front end input registers to the output register
// throughput: one ray per cycle; the whole pipe stalls while a result waits unaccepted
// latency set by 6 front stages, 66 square root cells, 1 setup stage, 32 divider cells, 1 output
// reset: valid bits cleared, near_limit returns to 1; no clearing pass
module ray_sphere_intersect_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // distance
    output logic         m_axis_tuser,  // hit
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata
);
    import rsi_pkg::*;

    logic                   en;
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [DIV_STEPS:0]     miss_reg;
    logic [30:0]            near_limit_reg;
    logic                   out_vld_reg;
    logic                   hit_reg;
    logic [31:0]            dist_reg;

    sq_t sq_s [SQ_STEPS+1];
    dv_t dn_s [DIV_STEPS+1];
    dv_t df_s [DIV_STEPS+1];

    sq_t         so;
    logic [65:0] hx;
    logic [65:0] num_n;
    logic [66:0] num_f;
    logic        near_ok, far_ok;
    dv_t         n_setup, f_setup;
    logic [31:0] t_n, t_f;
    logic        near_hit, far_hit;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign vld_next      = {vld_reg[PIPE_STAGES-2:0], s_axis_tvalid};

    rsi_front u_front (
        .clk     (clk),
        .en      (en),
        .in_data (s_axis_tdata),
        .sq_out  (sq_s[0])
    );

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .clk    (clk),
            .en     (en),
            .sq_in  (sq_s[k]),
            .sq_out (sq_s[k+1])
        );
    end

    // divider setup from root and h
    always_comb
    begin
        so      = sq_s[SQ_STEPS];
        hx      = {2'b00, so.hmag};
        near_ok = !so.hneg && (hx >= so.root);
        far_ok  = !so.hneg || (so.root >= hx);
        num_n   = hx - so.root;
        num_f   = so.hneg ? ({1'b0, so.root} - {1'b0, hx}) : ({1'b0, so.root} + {1'b0, hx});

        n_setup.ok  = near_ok;
        n_setup.sat = {14'd0, num_n} >= {so.a, 16'd0};
        n_setup.a   = so.a;
        n_setup.r   = {14'd0, num_n[65:16]};
        n_setup.nb  = {num_n[15:0], 16'd0};
        n_setup.q   = '0;

        f_setup.ok  = far_ok;
        f_setup.sat = {13'd0, num_f} >= {so.a, 16'd0};
        f_setup.a   = so.a;
        f_setup.r   = {13'd0, num_f[66:16]};
        f_setup.nb  = {num_f[15:0], 16'd0};
        f_setup.q   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn_s[0]     <= n_setup;
            df_s[0]     <= f_setup;
            miss_reg[0] <= so.miss;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                miss_reg[k+1] <= miss_reg[k];
            end
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        rsi_div_cell u_near (
            .clk    (clk),
            .en     (en),
            .dv_in  (dn_s[k]),
            .dv_out (dn_s[k+1])
        );
        rsi_div_cell u_far (
            .clk    (clk),
            .en     (en),
            .dv_in  (df_s[k]),
            .dv_out (df_s[k+1])
        );
    end

    // root pick against near limit
    assign t_n      = dn_s[DIV_STEPS].sat ? 32'hFFFF_FFFF : dn_s[DIV_STEPS].q;
    assign t_f      = df_s[DIV_STEPS].sat ? 32'hFFFF_FFFF : df_s[DIV_STEPS].q;
    assign near_hit = !miss_reg[DIV_STEPS] && dn_s[DIV_STEPS].ok && (t_n >= {1'b0, near_limit_reg});
    assign far_hit  = !miss_reg[DIV_STEPS] && df_s[DIV_STEPS].ok && (t_f >= {1'b0, near_limit_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= near_hit || far_hit;
            dist_reg <= near_hit ? t_n : (far_hit ? t_f : 32'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_vld_reg    <= 1'b0;
            near_limit_reg <= 31'd1;
        end
        else
        begin
            if (en)
            begin
                vld_reg     <= vld_next;
                out_vld_reg <= vld_reg[PIPE_STAGES-1];
            end
            if (cfg_we)
            begin
                near_limit_reg <= cfg_wdata;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = dist_reg;
    assign m_axis_tuser  = hit_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transaction not tracked");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipe moved during stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !hit_reg |-> dist_reg == 32'd0)
        else $error("miss with nonzero distance");

    a_hit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && hit_reg && !$past(cfg_we) |-> dist_reg >= {1'b0, near_limit_reg})
        else $error("hit below near limit");

endmodule

// File: tb/ray_sphere_intersect_core_chk.sv
// checker for ray_sphere_intersect_core: watches both stream channels,
// predicts hit and distance per ray and compares; depends on nothing but the ports
`timescale 1ns / 100ps

module ray_sphere_intersect_core_chk (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata,
    output int           errors,
    output int           pending,
    output int           hits_seen
);

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } isect_t;

    isect_t      expected_q[$];
    logic [30:0] near_lim;

    function automatic logic [31:0] scaled_root(input logic [135:0] num, input logic [63:0] a);
        logic [135:0] n16;
        logic [135:0] q;
        n16 = num << 16;
        if (n16 >= ({72'b0, a} << 32))
            return 32'hFFFF_FFFF;
        q = n16 / {72'b0, a};
        return q[31:0];
    endfunction

    function automatic isect_t trace_ray(input logic [191:0] v, input logic [30:0] nl);
        isect_t       r;
        logic signed [63:0] oc, dv, p;
        logic [63:0]  a, s2, hp, hn, hmag, cmag;
        logic         hneg, cneg;
        logic [135:0] hh, ac, d, s, c, wh, num;
        logic [31:0]  t;
        r = '0;
        a = 0; s2 = 0; hp = 0; hn = 0;
        for (int i = 0; i < 3; i++)
        begin
            oc = -$signed({{32{v[32*i+31]}}, v[32*i +: 32]});
            dv = $signed({{32{v[32*i+127]}}, v[32*i+96 +: 32]});
            p  = oc * dv;
            a  = a + 64'(dv * dv);
            s2 = s2 + 64'(oc * oc);
            if (p >= 0)
                hp = hp + 64'(p);
            else
                hn = hn + 64'(-p);
        end
        if (a == 0)
            return r;
        hneg = hn > hp;
        hmag = hneg ? hn - hp : hp - hn;
        cneg = s2 < 64'h4000_0000;
        cmag = cneg ? 64'h4000_0000 - s2 : s2 - 64'h4000_0000;
        hh = {72'b0, hmag} * {72'b0, hmag};
        ac = {72'b0, a} * {72'b0, cmag};
        if (cneg)
            d = hh + ac;
        else if (hh < ac)
            return r;
        else
            d = hh - ac;
        s = '0;
        for (int b = 65; b >= 0; b--)
        begin
            c = s | (136'd1 << b);
            if (c * c <= d)
                s = c;
        end
        wh = {72'b0, hmag};
        if (!hneg && wh >= s)
        begin
            t = scaled_root(wh - s, a);
            if (t >= {1'b0, nl})
            begin
                r.hit = 1'b1;
                r.distance = t;
                return r;
            end
        end
        if (!hneg)
            num = wh + s;
        else if (s >= wh)
            num = s - wh;
        else
            return r;
        t = scaled_root(num, a);
        if (t >= {1'b0, nl})
        begin
            r.hit = 1'b1;
            r.distance = t;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        isect_t got, want;
        if (!rst_n)
        begin
            near_lim = 31'd1;
            expected_q.delete();
            errors = 0;
            hits_seen = 0;
        end
        else
        begin
            if (cfg_we)
                near_lim = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(trace_ray(s_axis_tdata, near_lim));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit = m_axis_tuser;
                got.distance = m_axis_tdata;
                if (expected_q.size() == 0)
                    report("unexpected transaction", {31'b0, got.hit}, 32'h0);
                else
                begin
                    want = expected_q.pop_front();
                    if (got.hit) hits_seen++;
                    if (got.hit != want.hit)
                        report("hit", {31'b0, got.hit}, {31'b0, want.hit});
                    if (got.distance != want.distance)
                        report("distance", got.distance, want.distance);
                end
            end
        end
    end

endmodule

// File: tb/ray_sphere_intersect_core_tb.sv
// top of the ray_sphere_intersect_core testbench: clock, reset, ray stimulus,
// register phases and verdict; depends on ray_sphere_intersect_core_chk and the rtl
`timescale 1ns / 100ps

module ray_sphere_intersect_core_tb;

    localparam int ONE      = 32'h0001_0000;
    localparam int LIMIT    = 600000;
    localparam int DRAIN    = 120;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;   // distance
    logic         m_axis_tuser;   // hit
    logic         cfg_we;
    logic [30:0]  cfg_wdata;
    logic         quiet;
    int           errors, pending, hits_seen, cycles, rays;

    ray_sphere_intersect_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    ray_sphere_intersect_core_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending),
        .hits_seen     (hits_seen)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 8);
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("ray_sphere_intersect_core_tb: errors");
            $finish;
        end
    end

    function automatic logic [191:0] pack_ray(input int ox, oy, oz, dx, dy, dz);
        return {dz, dy, dx, oz, oy, ox};
    endfunction

    function automatic int spread(input int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    task automatic send_ray(input logic [191:0] v);
        while (!quiet && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do
            @(posedge clk);
        while (!s_axis_tready);
        rays++;
    endtask

    task automatic settle_and_write(input logic [30:0] nl);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= nl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_rays();
        send_ray(pack_ray(0, 0, -2 * ONE, 0, 0, ONE));            // straight hit
        send_ray(pack_ray(0, 0, 0, ONE, 0, 0));                   // from inside
        send_ray(pack_ray(2 * ONE, 2 * ONE, 0, 0, 0, ONE));       // clear miss
        send_ray(pack_ray(0, 0, 2 * ONE, 0, 0, ONE));             // sphere behind
        send_ray(pack_ray(ONE / 2, 0, -2 * ONE, 0, 0, ONE));      // tangent
        send_ray(pack_ray(0, 0, -ONE / 2, 0, 0, ONE));            // on the surface
        send_ray(pack_ray(0, 0, -2 * ONE, 0, 0, 1));              // saturating distance
        send_ray(pack_ray(ONE, 0, 0, 0, 0, 0));                   // zero direction
        send_ray(pack_ray(0, 0, 0, 0, 0, 0));
        send_ray(pack_ray(0, 0, -4 * ONE, 0, 0, 64 * ONE));       // short distance
        send_ray({6{32'h8000_0000}});
        send_ray({6{32'h7FFF_FFFF}});
        send_ray({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
        send_ray({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
        send_ray({{3{32'h0000_0001}}, {3{32'h0000_0000}}});
        send_ray({{3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}});
        send_ray(pack_ray(0, 0, -ONE, 0, 0, -ONE));               // pointing away
        send_ray(pack_ray(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    endtask

    task automatic random_rays(input int n);
        int ox, oy, oz, kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(99);
            ox = spread(3 * ONE);
            oy = spread(3 * ONE);
            oz = spread(3 * ONE);
            if (kind < 65)
                send_ray(pack_ray(ox, oy, oz,
                                  spread(ONE / 2) - ox, spread(ONE / 2) - oy,
                                  spread(ONE / 2) - oz));
            else if (kind < 80)
                send_ray(pack_ray(ox, oy, oz, spread(2 * ONE), spread(2 * ONE),
                                  spread(2 * ONE)));
            else
                send_ray({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        quiet         = 1'b0;
        cycles        = 0;
        rays          = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rays();
        random_rays(300);
        settle_and_write(31'd0);
        directed_rays();
        random_rays(300);
        quiet <= 1'b1;
        random_rays(300);
        quiet <= 1'b0;
        settle_and_write(31'h7FFF_FFFF);
        directed_rays();
        random_rays(100);
        settle_and_write(31'($urandom_range(32'h0003_0000)));
        random_rays(400);
        settle_and_write(31'($urandom));
        random_rays(100);
        settle_and_write(31'd1);
        random_rays(150);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("covered %0d rays over six near-limit settings, %0d hits returned",
                 rays, hits_seen);
        if (errors == 0)
            $display("ray_sphere_intersect_core_tb: clean");
        else
            $display("ray_sphere_intersect_core_tb: errors");
        $finish;
    end

endmodule
